// ===== rtl/core/hall_speed_angle_estimator_core_defines.svh =====
// ----------------------------------------------------------------------------
// hall speed and angle estimator assertion macros
// shared concurrent assertion forms, clocked on clk; HSAE_ASSERT is disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HALL_SPEED_ANGLE_ESTIMATOR_CORE_DEFINES_SVH
`define HALL_SPEED_ANGLE_ESTIMATOR_CORE_DEFINES_SVH

// property checked only outside reset
`define HSAE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define HSAE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hsae_pkg.sv =====
// ----------------------------------------------------------------------------
// hsae_pkg
// constants, register indexes and lookup functions of the hall estimator
// ----------------------------------------------------------------------------
package hsae_pkg;

    // data and field widths
    localparam int DATA_W          = 32;
    localparam int SECTOR_W        = 3;
    localparam int ANGLE_W         = 20;
    localparam int FINE_W          = 17;
    localparam int COUNT_WIDTH_DEF = 24;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 56;
    localparam int CFG_INDEX_W     = 1;

    // config register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_NUMERATOR = 1'b1;

    // config reset values
    localparam logic [DATA_W-1:0] SAMPLE_PERIOD_RST   = 32'd429497;
    localparam logic [DATA_W-1:0] SPEED_NUMERATOR_RST = 32'd85786420;

    // pi/3 in Q.16 radians
    localparam logic [FINE_W-1:0] ANG_PI3 = 17'd68629;

    // hall code a*4 + b*2 + c to sector, 0 for codes 0 and 7
    function automatic logic [SECTOR_W-1:0] decode_sector(input logic [2:0] code);
        logic [SECTOR_W-1:0] s;
        case (code)
            3'd4:    s = 3'd1;
            3'd6:    s = 3'd2;
            3'd2:    s = 3'd3;
            3'd3:    s = 3'd4;
            3'd1:    s = 3'd5;
            3'd5:    s = 3'd6;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // coarse angle (sector - 1) * pi/3 - pi/6
    function automatic logic signed [ANGLE_W-1:0] coarse_angle(input logic [SECTOR_W-1:0] s);
        logic signed [ANGLE_W-1:0] a;
        case (s)
            3'd0:    a = -20'sd102944;
            3'd1:    a = -20'sd34315;
            3'd2:    a = 20'sd34314;
            3'd3:    a = 20'sd102943;
            3'd4:    a = 20'sd171572;
            3'd5:    a = 20'sd240201;
            3'd6:    a = 20'sd308830;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/hall_speed_angle_estimator_core.sv =====
// ----------------------------------------------------------------------------
// hall_speed_angle_estimator_core
// hall sector decode, speed estimate and interpolated rotor angle
// ----------------------------------------------------------------------------
// One item per sample tick gives one result item. The result is loaded into
// the output register in the finish step, after the prepare and multiply
// steps and, on a tick that updates the speed, the divide step before them.
// The next item is accepted only once the block is back in idle. The speed is
// a 32-step restoring divider that takes one quotient bit a cycle, and the
// trapezoid increment is a 32-step shift-add multiplier that takes one bit of
// the sample period a cycle. The result sits in an output register so a
// stalled output does not hold up the next item's work; only a result still
// waiting there holds the next item in its finish step.
// ----------------------------------------------------------------------------
`include "hall_speed_angle_estimator_core_defines.svh"

module hall_speed_angle_estimator_core #(
    parameter int COUNT_WIDTH = hsae_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input item: [0] hall_a, [1] hall_b, [2] hall_c
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hsae_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result item: [2:0] sector, [34:3] speed, [54:35] rotor_angle
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hsae_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // config write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hsae_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hsae_pkg::DATA_W-1:0]         cfg_data
);

    import hsae_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_W - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [DATA_W-1:0]          period_reg, period_next;
    logic [DATA_W-1:0]          numer_reg, numer_next;
    logic [COUNT_WIDTH-1:0]     sample_count_reg, sample_count_next;
    logic                       change_reg, change_next;
    logic [SECTOR_W-1:0]        last_sector_reg, last_sector_next;
    logic [FINE_W-1:0]          sector_angle_reg, sector_angle_next;
    logic [DATA_W-1:0]          last_speed_reg, last_speed_next;
    logic [DATA_W-1:0]          speed_reg, speed_next;
    logic [FINE_W-1:0]          base_reg, base_next;
    logic [DATA_W-1:0]          quot_reg, quot_next;
    logic [COUNT_WIDTH-1:0]     rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0]     divisor_reg, divisor_next;
    logic [CNT_W-1:0]           bit_cnt_reg, bit_cnt_next;
    logic [DATA_W:0]            sum_reg, sum_next;
    logic [DATA_W-1:0]          mpl_reg, mpl_next;
    logic [DATA_W:0]            acc_reg, acc_next;
    logic [2:0]                 low_reg, low_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SECTOR_W-1:0]        out_sector_reg, out_sector_next;
    logic [DATA_W-1:0]          out_speed_reg, out_speed_next;
    logic [ANGLE_W-1:0]         out_angle_reg, out_angle_next;

    logic                       in_fire;
    logic [SECTOR_W-1:0]        in_sector;
    logic [COUNT_WIDTH-1:0]     count_inc;
    logic                       sector_changed;
    logic                       do_div;
    logic [COUNT_WIDTH:0]       div_shift;
    logic [COUNT_WIDTH:0]       div_diff;
    logic                       div_ge;
    logic [DATA_W+1:0]          mul_sum;
    logic [DATA_W+3:0]          step;
    logic                       step_over;
    logic [FINE_W:0]            fine_sum;
    logic [FINE_W-1:0]          fine;
    logic                       out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_angle_reg, out_speed_reg, out_sector_reg};

    // input decode and sample count
    assign in_fire        = s_tvalid && s_tready;
    assign in_sector      = decode_sector({s_tdata[0], s_tdata[1], s_tdata[2]});
    assign count_inc      = (sample_count_reg == COUNT_MAX) ? sample_count_reg
                                                            : sample_count_reg + 1'b1;
    assign sector_changed = (in_sector != last_sector_reg);
    assign do_div         = sector_changed && change_reg;

    // restoring divide step, one quotient bit
    assign div_shift = {rem_reg, quot_reg[DATA_W-1]};
    assign div_diff  = div_shift - {1'b0, divisor_reg};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});

    // shift-add multiply step, one period bit
    assign mul_sum = {1'b0, acc_reg} + (mpl_reg[0] ? {1'b0, sum_reg} : '0);

    // trapezoid increment is product >> 29, fine angle clamped at pi/3
    assign step      = {acc_reg, low_reg};
    assign step_over = (step > (DATA_W+4)'(ANG_PI3));
    assign fine_sum  = {1'b0, base_reg} + step[FINE_W:0];
    assign fine      = (step_over || (fine_sum > {1'b0, ANG_PI3})) ? ANG_PI3
                                                                   : fine_sum[FINE_W-1:0];
    assign out_free  = !out_valid_reg || m_tready;

    // next state and datapath
    always_comb
    begin
        state_next        = state_reg;
        period_next       = period_reg;
        numer_next        = numer_reg;
        sample_count_next = sample_count_reg;
        change_next       = change_reg;
        last_sector_next  = last_sector_reg;
        sector_angle_next = sector_angle_reg;
        last_speed_next   = last_speed_reg;
        speed_next        = speed_reg;
        base_next         = base_reg;
        quot_next         = quot_reg;
        rem_next          = rem_reg;
        divisor_next      = divisor_reg;
        bit_cnt_next      = bit_cnt_reg;
        sum_next          = sum_reg;
        mpl_next          = mpl_reg;
        acc_next          = acc_reg;
        low_next          = low_reg;
        out_valid_next    = out_valid_reg;
        out_sector_next   = out_sector_reg;
        out_speed_next    = out_speed_reg;
        out_angle_next    = out_angle_reg;

        // config writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SAMPLE_PERIOD:   period_next = cfg_data;
                REG_SPEED_NUMERATOR: numer_next  = cfg_data;
                default:             ;
            endcase
        end

        // result taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_sector_next  = in_sector;
                    speed_next        = last_speed_reg;
                    base_next         = sector_changed ? '0 : sector_angle_reg;
                    sample_count_next = count_inc;
                    bit_cnt_next      = '0;
                    if (sector_changed)
                    begin
                        change_next = !change_reg;
                    end
                    if (do_div)
                    begin
                        sample_count_next = '0;
                        divisor_next      = count_inc;
                        quot_next         = numer_reg;
                        rem_next          = '0;
                        state_next        = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_DIV:
            begin
                quot_next    = {quot_reg[DATA_W-2:0], div_ge};
                rem_next     = div_ge ? div_diff[COUNT_WIDTH-1:0]
                                      : div_shift[COUNT_WIDTH-1:0];
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    speed_next = {quot_reg[DATA_W-2:0], div_ge};
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                sum_next     = {1'b0, speed_reg} + {1'b0, last_speed_reg};
                mpl_next     = period_reg;
                acc_next     = '0;
                low_next     = '0;
                bit_cnt_next = '0;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next     = mul_sum[DATA_W+1:1];
                low_next     = {mul_sum[0], low_reg[2:1]};
                mpl_next     = mpl_reg >> 1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    sector_angle_next = fine;
                    last_speed_next   = speed_reg;
                    out_valid_next    = 1'b1;
                    out_sector_next   = last_sector_reg;
                    out_speed_next    = speed_reg;
                    out_angle_next    = coarse_angle(last_sector_reg)
                                      + $signed({3'b000, fine});
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            period_reg       <= SAMPLE_PERIOD_RST;
            numer_reg        <= SPEED_NUMERATOR_RST;
            sample_count_reg <= '0;
            change_reg       <= 1'b0;
            last_sector_reg  <= '0;
            sector_angle_reg <= '0;
            last_speed_reg   <= '0;
            bit_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            period_reg       <= period_next;
            numer_reg        <= numer_next;
            sample_count_reg <= sample_count_next;
            change_reg       <= change_next;
            last_sector_reg  <= last_sector_next;
            sector_angle_reg <= sector_angle_next;
            last_speed_reg   <= last_speed_next;
            bit_cnt_reg      <= bit_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        speed_reg      <= speed_next;
        base_reg       <= base_next;
        quot_reg       <= quot_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        sum_reg        <= sum_next;
        mpl_reg        <= mpl_next;
        acc_reg        <= acc_next;
        low_reg        <= low_next;
        out_sector_reg <= out_sector_next;
        out_speed_reg  <= out_speed_next;
        out_angle_reg  <= out_angle_next;
    end

    // checks
    `HSAE_ASSERT_ALWAYS(a_fine_angle_clamped,
        sector_angle_reg <= ANG_PI3,
        "fine angle above pi/3")
    `HSAE_ASSERT(a_accept_leaves_idle,
        in_fire |=> !s_tready,
        "block took item but stayed idle")
    `HSAE_ASSERT(a_speed_update_clears_count,
        (in_fire && do_div) |=> (sample_count_reg == '0),
        "sample count not cleared on speed update")
    `HSAE_ASSERT(a_result_from_finish,
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN),
        "result loaded outside finish step")

endmodule

// ===== bench/hall_speed_angle_estimator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_speed_angle_estimator_core_tb
// Drives hall sample items through the estimator and checks each result item
// against a cycle-free model of sector decode, speed division and angle
// integration. It covers reset settings, extreme register values and long
// random rotations with glitches, with random stalls on both sides.
// ----------------------------------------------------------------------------
module hall_speed_angle_estimator_core_tb;

    import hsae_pkg::*;

    localparam int COUNT_W    = COUNT_WIDTH_DEF;
    localparam int ANGLE_PI6  = 34315;
    localparam logic [DATA_W-1:0] U32_MAX = 32'hFFFF_FFFF;

    // one result item split into fields
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [DATA_W-1:0]   speed;
        logic [ANGLE_W-1:0]  rotor_angle;
    } hall_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [DATA_W-1:0]       cfg_data;

    // model copy of registers and state
    logic [DATA_W-1:0]   model_period;
    logic [DATA_W-1:0]   model_numerator;
    logic [COUNT_W-1:0]  model_count;
    logic                model_change;
    logic [SECTOR_W-1:0] model_last_sector;
    logic [FINE_W-1:0]   model_fine_angle;
    logic [DATA_W-1:0]   model_last_speed;

    hall_result_t expected_results[$];
    int           error_count;
    logic         no_idle;

    // hall code of each sector, index 0 is an invalid code
    logic [2:0] sector_code [0:6];

    hall_speed_angle_estimator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock, low first so the first rising edge comes with reset applied
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // expected result of one sample tick, advances the model state
    function automatic hall_result_t predict_tick(input logic [2:0] code);
        hall_result_t        r;
        logic [SECTOR_W-1:0] sector;
        logic [DATA_W-1:0]   speed;
        logic [FINE_W-1:0]   base;
        logic [DATA_W:0]     speed_sum;
        logic [95:0]         fine_wide;
        int                  angle;
        case (code)
            3'd4:    sector = 3'd1;
            3'd6:    sector = 3'd2;
            3'd2:    sector = 3'd3;
            3'd3:    sector = 3'd4;
            3'd1:    sector = 3'd5;
            3'd5:    sector = 3'd6;
            default: sector = 3'd0;
        endcase
        speed = model_last_speed;
        base  = model_fine_angle;
        // saturating sample count
        if (model_count != '1)
            model_count = model_count + 1'b1;
        // speed update on every second sector change
        if (sector != model_last_sector)
        begin
            base = '0;
            if (model_change)
            begin
                speed        = model_numerator / {{(DATA_W-COUNT_W){1'b0}}, model_count};
                model_count  = '0;
                model_change = 1'b0;
            end
            else
                model_change = 1'b1;
        end
        // trapezoid increment, clamped at pi/3
        speed_sum = {1'b0, speed} + {1'b0, model_last_speed};
        fine_wide = {79'b0, base}
                  + (({64'b0, model_period} * {63'b0, speed_sum}) >> 29);
        if (fine_wide > {79'b0, ANG_PI3})
            fine_wide = {79'b0, ANG_PI3};
        angle = (int'(sector) - 1) * int'(ANG_PI3) + int'(fine_wide[FINE_W-1:0]) - ANGLE_PI6;
        model_last_sector = sector;
        model_fine_angle  = fine_wide[FINE_W-1:0];
        model_last_speed  = speed;
        r.sector      = sector;
        r.speed       = speed;
        r.rotor_angle = angle[ANGLE_W-1:0];
        return r;
    endfunction

    // send one sample item, entered and left at a falling edge
    task automatic send_hall(input logic [2:0] code);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, code[0], code[1], code[2]};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(predict_tick(code));
        @(negedge clk);
    endtask

    // let all results drain with the input side quiet
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // one register write, block idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_SAMPLE_PERIOD)
            model_period = value;
        else
            model_numerator = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [DATA_W-1:0] period,
                              input logic [DATA_W-1:0] numerator);
        wait_idle();
        write_reg(REG_SAMPLE_PERIOD, period);
        write_reg(REG_SPEED_NUMERATOR, numerator);
    endtask

    // random rotation: mostly clean sector walks, some noise and glitches
    task automatic run_rotation(input int item_count);
        int sent;
        int sector;
        int dir;
        int dwell;
        int kind;
        sent   = 0;
        sector = $urandom_range(1, 6);
        dir    = ($urandom_range(0, 1) == 0) ? 1 : -1;
        while (sent < item_count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                // clean dwell in one sector, then step
                dwell = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 12);
                repeat (dwell)
                    send_hall(sector_code[sector]);
                sent   = sent + dwell;
                sector = (sector + dir + 5) % 6 + 1;
                if ($urandom_range(0, 15) == 0)
                    dir = -dir;
            end
            else if (kind == 7)
            begin
                // any code at all
                send_hall(3'($urandom_range(0, 7)));
                sent = sent + 1;
            end
            else if (kind == 8)
            begin
                // invalid code glitch
                dwell = $urandom_range(1, 3);
                repeat (dwell)
                    send_hall(($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7);
                sent = sent + dwell;
            end
            else
            begin
                // jump to any sector
                sector = $urandom_range(1, 6);
                send_hall(sector_code[sector]);
                sent = sent + 1;
            end
        end
    endtask

    // every hall code, then invalid code 7 to 0 which is no sector change
    task automatic test_hall_codes();
        for (int code = 0; code < 8; code++)
            send_hall(code[2:0]);
        send_hall(3'd7);
        send_hall(3'd0);
    endtask

    // one item per sector forward, then backward
    task automatic test_rotation_directed();
        for (int s = 1; s <= 6; s++)
            send_hall(sector_code[s]);
        for (int s = 5; s >= 1; s--)
            send_hall(sector_code[s]);
    endtask

    // extreme register values, clamp of the fine angle included
    task automatic test_config_extremes();
        logic [DATA_W-1:0] periods    [0:4];
        logic [DATA_W-1:0] numerators [0:4];
        periods    = '{32'd1, U32_MAX, 32'd1, U32_MAX, SAMPLE_PERIOD_RST};
        numerators = '{32'd1, U32_MAX, U32_MAX, 32'd1, SPEED_NUMERATOR_RST};
        for (int i = 0; i < 5; i++)
        begin
            set_config(periods[i], numerators[i]);
            run_rotation(30);
        end
    endtask

    // long random phases with varied settings and idle patterns
    task automatic test_random_rotation();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 3)
                0: set_config(SAMPLE_PERIOD_RST, SPEED_NUMERATOR_RST);
                1: set_config($urandom_range(1, 32'h0010_0000), $urandom_range(1, U32_MAX));
                default: set_config($urandom_range(1, U32_MAX), $urandom_range(1, U32_MAX));
            endcase
            for (int part = 0; part < 2; part++)
            begin
                no_idle = (part == 1);
                run_rotation(80);
            end
            no_idle = 1'b0;
        end
    endtask

    // result sink with random stalls and field checks
    initial
    begin : result_sink
        int           stall;
        hall_result_t want;
        hall_result_t got;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.sector      = m_tdata[2:0];
            got.speed       = m_tdata[34:3];
            got.rotor_angle = m_tdata[54:35];
            if (expected_results.size() == 0)
            begin
                $error("result item with none expected: sector %0d speed %0d rotor_angle %0d",
                       got.sector, got.speed, $signed(got.rotor_angle));
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.sector !== want.sector)
                begin
                    $error("sector: expected %0d, actual %0d", want.sector, got.sector);
                    error_count++;
                end
                if (got.speed !== want.speed)
                begin
                    $error("speed: expected %0d, actual %0d", want.speed, got.speed);
                    error_count++;
                end
                if (got.rotor_angle !== want.rotor_angle)
                begin
                    $error("rotor_angle: expected %0d, actual %0d",
                           $signed(want.rotor_angle), $signed(got.rotor_angle));
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("hall_speed_angle_estimator_core_tb failed");
        $finish;
    end

    // test sequence
    initial
    begin
        sector_code = '{3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5};
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_SAMPLE_PERIOD;
        cfg_data    = '0;
        no_idle     = 1'b0;
        error_count = 0;

        // reset state of the model
        model_period      = SAMPLE_PERIOD_RST;
        model_numerator   = SPEED_NUMERATOR_RST;
        model_count       = '0;
        model_change      = 1'b0;
        model_last_sector = '0;
        model_fine_angle  = '0;
        model_last_speed  = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_hall_codes();
        test_rotation_directed();
        test_config_extremes();
        test_random_rotation();

        // drain and allow for late extra items
        wait_idle();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("hall_speed_angle_estimator_core_tb passed");
        else
            $display("hall_speed_angle_estimator_core_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hsae_pkg.sv
rtl/core/hall_speed_angle_estimator_core.sv
bench/hall_speed_angle_estimator_core_tb.sv
